### rtl/core/tbmc_pkg.sv
// Shared types and constants for the two-button mode controller.
package tbmc_pkg;

	localparam int unsigned CntW = 8;

	typedef logic [2:0] mode_t;
	typedef logic [2:0] presc_t;
	typedef logic [CntW-1:0] cnt_t;

	localparam mode_t  MODE_MIN   = 3'd1;
	localparam mode_t  MODE_MAX   = 3'd4;
	localparam mode_t  MODE_PULSE = 3'd2;
	localparam presc_t PRESC_MIN  = 3'd1;
	localparam presc_t PRESC_MAX  = 3'd5;

	localparam mode_t  MODE_RESET       = MODE_MIN;
	localparam presc_t PRESC_RESET      = PRESC_MAX;
	localparam cnt_t   LONG_PRESS_RESET = 8'd100;

	// Long-press indicator codes
	typedef enum logic [1:0] {
		LP_NONE  = 2'd0,
		LP_LEFT  = 2'd1,
		LP_RIGHT = 2'd2
	} lp_shown_t;

	typedef struct packed {
		logic   chord_latched;
		logic   left_down;
		logic   right_down;
		cnt_t   left_ticks;
		cnt_t   right_ticks;
		logic   hold_flag;
		mode_t  mode;
		presc_t prescaler;
		logic   period_view;
	} ctl_state_t;

	// Packed so that mode lands in the lowest bits
	typedef struct packed {
		lp_shown_t long_press_shown;
		logic      pulse_request;
		logic      mode_changed;
		logic      values_changed;
		logic      hold_active;
		logic      period_display;
		presc_t    prescaler_select;
		mode_t     mode;
	} result_t;

	localparam int unsigned ResW  = $bits(result_t);
	localparam int unsigned OutDW = ((ResW + 7) / 8) * 8;

endpackage

### rtl/core/tbmc_step.sv
// Per-tick button classification and settings update.
module tbmc_step (
	input  tbmc_pkg::ctl_state_t cur,
	input  tbmc_pkg::cnt_t       long_press_ticks,
	input  logic                 left_rel,
	input  logic                 right_rel,
	output tbmc_pkg::ctl_state_t nxt,
	output tbmc_pkg::result_t    res
);
	import tbmc_pkg::*;

	function automatic mode_t mode_down(input mode_t m);
		if (m <= MODE_MIN || m > MODE_MAX) begin
			return MODE_MAX;
		end
		return m - 3'd1;
	endfunction

	function automatic mode_t mode_up(input mode_t m);
		if (m >= MODE_MAX || m < MODE_MIN) begin
			return MODE_MIN;
		end
		return m + 3'd1;
	endfunction

	logic      vc;
	logic      mc;
	logic      pr;
	lp_shown_t shown;

	always_comb begin
		nxt = cur;
		vc  = 1'b0;
		mc  = 1'b0;
		pr  = 1'b0;
		if (cur.chord_latched) begin
			// Wait for both buttons up
			if (left_rel && right_rel) begin
				nxt.chord_latched = 1'b0;
				nxt.left_down     = 1'b0;
				nxt.right_down    = 1'b0;
				nxt.left_ticks    = '0;
				nxt.right_ticks   = '0;
			end
		end else if (!left_rel && !right_rel) begin
			nxt.hold_flag     = !cur.hold_flag;
			nxt.chord_latched = 1'b1;
			nxt.left_ticks    = '0;
			nxt.right_ticks   = '0;
		end else begin
			// Left first; right sees any mode or prescaler change from left
			if (cur.left_down) begin
				if (left_rel) begin
					if (cur.left_ticks < long_press_ticks) begin
						if (!cur.hold_flag) begin
							if (nxt.mode == MODE_PULSE) begin
								nxt.period_view = !nxt.period_view;
							end else if (nxt.prescaler > PRESC_MIN) begin
								nxt.prescaler = nxt.prescaler - 3'd1;
							end
							vc = 1'b1;
						end
					end else if (!cur.hold_flag) begin
						nxt.mode = mode_down(nxt.mode);
						mc = 1'b1;
					end
					nxt.left_down  = 1'b0;
					nxt.left_ticks = '0;
				end else if (cur.left_ticks < long_press_ticks) begin
					nxt.left_ticks = cur.left_ticks + 8'd1;
				end
			end else if (!left_rel) begin
				nxt.left_down = 1'b1;
			end

			if (cur.right_down) begin
				if (right_rel) begin
					if (cur.right_ticks < long_press_ticks) begin
						// Burst request and change flag pass through hold
						if (nxt.mode == MODE_PULSE) begin
							pr = 1'b1;
						end else if (!cur.hold_flag && nxt.prescaler < PRESC_MAX) begin
							nxt.prescaler = nxt.prescaler + 3'd1;
						end
						vc = 1'b1;
					end else if (!cur.hold_flag) begin
						nxt.mode = mode_up(nxt.mode);
						mc = 1'b1;
					end
					nxt.right_down  = 1'b0;
					nxt.right_ticks = '0;
				end else if (cur.right_ticks < long_press_ticks) begin
					nxt.right_ticks = cur.right_ticks + 8'd1;
				end
			end else if (!right_rel) begin
				nxt.right_down = 1'b1;
			end
		end
	end

	always_comb begin
		shown = LP_NONE;
		if (!nxt.hold_flag) begin
			if (nxt.left_ticks >= long_press_ticks) begin
				shown = LP_LEFT;
			end else if (nxt.right_ticks >= long_press_ticks) begin
				shown = LP_RIGHT;
			end
		end
	end

	always_comb begin
		res.mode             = nxt.mode;
		res.prescaler_select = nxt.prescaler;
		res.period_display   = nxt.period_view;
		res.hold_active      = nxt.hold_flag;
		res.values_changed   = vc;
		res.mode_changed     = mc;
		res.pulse_request    = pr;
		res.long_press_shown = shown;
	end

endmodule

### rtl/core/two_button_mode_controller.sv
// Top level: input register, settings state and result register with flow control.
// Path: each input transfer lands in the input register, then its result in the result register.
// Throughput: one input item per cycle while the result side accepts, one result per item.
// Back-pressure on the result side holds state and result; the input stalls once both are full.
// Reset (arst_n low): mode 1, prescaler 5, period view, hold clear,
// no press tracked, long-press threshold 100 ticks.
module two_button_mode_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [0] left_button_level, [1] right_button_level
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [tbmc_pkg::OutDW-1:0]    m_axis_tdata,  // [2:0] mode, [5:3] prescaler_select,
	                                                     // [6] period_display, [7] hold_active,
	                                                     // [8] values_changed, [9] mode_changed,
	                                                     // [10] pulse_request, [12:11] long_press_shown
	input  logic                          cfg_we,
	input  logic [7:0]                    cfg_wdata
);
	import tbmc_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nxt;
	cnt_t       lpt_q;
	logic       valid_s1;
	logic [1:0] lvl_s1;
	logic       out_valid_q;
	result_t    res_q;
	result_t    res_nxt;
	logic       advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	tbmc_step u_step (
		.cur              (state_q),
		.long_press_ticks (lpt_q),
		.left_rel         (lvl_s1[0]),
		.right_rel        (lvl_s1[1]),
		.nxt              (state_nxt),
		.res              (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpt_q <= LONG_PRESS_RESET;
		end else if (cfg_we) begin
			lpt_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			lvl_s1 <= s_axis_tdata[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				chord_latched: 1'b0,
				left_down:     1'b0,
				right_down:    1'b0,
				left_ticks:    '0,
				right_ticks:   '0,
				hold_flag:     1'b0,
				mode:          MODE_RESET,
				prescaler:     PRESC_RESET,
				period_view:   1'b1
			};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OutDW-ResW){1'b0}}, res_q};

`ifndef NO_ASSERTIONS
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.mode >= MODE_MIN && res_q.mode <= MODE_MAX))
		else $error("mode out of range");

	a_presc_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.prescaler_select >= PRESC_MIN &&
			res_q.prescaler_select <= PRESC_MAX))
		else $error("prescaler out of range");

	a_hold_no_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.hold_active) |-> (res_q.long_press_shown == LP_NONE))
		else $error("long press shown while hold active");

	a_pulse_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.pulse_request) |->
			(res_q.mode == MODE_PULSE && res_q.values_changed))
		else $error("pulse request outside pulse mode");

	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without an item");
`endif

endmodule

### bench/tb.sv
// Self-checking testbench for the two-button mode controller stream interface.
`timescale 1ns / 1ps

module tb;
	import tbmc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 100000;

	typedef enum bit {BTN_LEFT, BTN_RIGHT} button_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = '0;    // [0] left_button_level, [1] right_button_level
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutDW-1:0]    m_axis_tdata;         // [2:0] mode, [5:3] prescaler_select,
	                                           // [6] period_display, [7] hold_active,
	                                           // [8] values_changed, [9] mode_changed,
	                                           // [10] pulse_request, [12:11] long_press_shown
	logic                cfg_we = 1'b0;
	logic [7:0]          cfg_wdata = '0;

	// Predictor copy of the controller settings and the press threshold
	ctl_state_t          ctl_copy;
	cnt_t                press_limit;
	result_t             settings_due[$];
	result_t             got_res;
	result_t             want_res;

	int unsigned         errors = 0;
	int unsigned         ticks_sent = 0;
	int unsigned         cycle_count = 0;
	int unsigned         rx_hold_cycles = 0;
	bit                  quiet = 1'b0;

	two_button_mode_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic void clear_settings_copy();
		ctl_copy.chord_latched = 1'b0;
		ctl_copy.left_down     = 1'b0;
		ctl_copy.right_down    = 1'b0;
		ctl_copy.left_ticks    = '0;
		ctl_copy.right_ticks   = '0;
		ctl_copy.hold_flag     = 1'b0;
		ctl_copy.mode          = MODE_RESET;
		ctl_copy.prescaler     = PRESC_RESET;
		ctl_copy.period_view   = 1'b1;
		press_limit            = LONG_PRESS_RESET;
	endfunction

	// One tick: update the settings copy and return the result it produces
	function automatic result_t advance_buttons(input logic left_up, input logic right_up);
		result_t r;
		logic    vc;
		logic    mc;
		logic    pr;
		vc = 1'b0;
		mc = 1'b0;
		pr = 1'b0;
		if (ctl_copy.chord_latched) begin
			if (left_up && right_up) begin
				ctl_copy.chord_latched = 1'b0;
				ctl_copy.left_down     = 1'b0;
				ctl_copy.right_down    = 1'b0;
				ctl_copy.left_ticks    = '0;
				ctl_copy.right_ticks   = '0;
			end
		end else if (!left_up && !right_up) begin
			ctl_copy.hold_flag     = ~ctl_copy.hold_flag;
			ctl_copy.chord_latched = 1'b1;
			ctl_copy.left_ticks    = '0;
			ctl_copy.right_ticks   = '0;
		end else begin
			if (ctl_copy.left_down) begin
				if (left_up) begin
					if (ctl_copy.left_ticks < press_limit) begin
						if (!ctl_copy.hold_flag) begin
							if (ctl_copy.mode == MODE_PULSE)
								ctl_copy.period_view = ~ctl_copy.period_view;
							else if (ctl_copy.prescaler > PRESC_MIN)
								ctl_copy.prescaler = presc_t'(ctl_copy.prescaler - 1'b1);
							vc = 1'b1;
						end
					end else if (!ctl_copy.hold_flag) begin
						if (ctl_copy.mode <= MODE_MIN || ctl_copy.mode > MODE_MAX)
							ctl_copy.mode = MODE_MAX;
						else
							ctl_copy.mode = mode_t'(ctl_copy.mode - 1'b1);
						mc = 1'b1;
					end
					ctl_copy.left_down  = 1'b0;
					ctl_copy.left_ticks = '0;
				end else if (ctl_copy.left_ticks < press_limit) begin
					ctl_copy.left_ticks = cnt_t'(ctl_copy.left_ticks + 1'b1);
				end
			end else if (!left_up) begin
				ctl_copy.left_down = 1'b1;
			end

			if (ctl_copy.right_down) begin
				if (right_up) begin
					if (ctl_copy.right_ticks < press_limit) begin
						// a short right press still counts under hold
						if (ctl_copy.mode == MODE_PULSE)
							pr = 1'b1;
						else if (!ctl_copy.hold_flag && ctl_copy.prescaler < PRESC_MAX)
							ctl_copy.prescaler = presc_t'(ctl_copy.prescaler + 1'b1);
						vc = 1'b1;
					end else if (!ctl_copy.hold_flag) begin
						if (ctl_copy.mode >= MODE_MAX || ctl_copy.mode < MODE_MIN)
							ctl_copy.mode = MODE_MIN;
						else
							ctl_copy.mode = mode_t'(ctl_copy.mode + 1'b1);
						mc = 1'b1;
					end
					ctl_copy.right_down  = 1'b0;
					ctl_copy.right_ticks = '0;
				end else if (ctl_copy.right_ticks < press_limit) begin
					ctl_copy.right_ticks = cnt_t'(ctl_copy.right_ticks + 1'b1);
				end
			end else if (!right_up) begin
				ctl_copy.right_down = 1'b1;
			end
		end

		r.long_press_shown = LP_NONE;
		if (!ctl_copy.hold_flag) begin
			if (ctl_copy.left_ticks >= press_limit)
				r.long_press_shown = LP_LEFT;
			else if (ctl_copy.right_ticks >= press_limit)
				r.long_press_shown = LP_RIGHT;
		end
		r.mode             = ctl_copy.mode;
		r.prescaler_select = ctl_copy.prescaler;
		r.period_display   = ctl_copy.period_view;
		r.hold_active      = ctl_copy.hold_flag;
		r.values_changed   = vc;
		r.mode_changed     = mc;
		r.pulse_request    = pr;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_res = result_t'(m_axis_tdata[ResW-1:0]);
			if (settings_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h",
					$time, m_axis_tdata);
				errors++;
			end else begin
				want_res = settings_due.pop_front();
				check_field("mode", 8'(want_res.mode), 8'(got_res.mode));
				check_field("prescaler_select", 8'(want_res.prescaler_select),
					8'(got_res.prescaler_select));
				check_field("period_display", 8'(want_res.period_display),
					8'(got_res.period_display));
				check_field("hold_active", 8'(want_res.hold_active),
					8'(got_res.hold_active));
				check_field("values_changed", 8'(want_res.values_changed),
					8'(got_res.values_changed));
				check_field("mode_changed", 8'(want_res.mode_changed),
					8'(got_res.mode_changed));
				check_field("pulse_request", 8'(want_res.pulse_request),
					8'(got_res.pulse_request));
				check_field("long_press_shown", 8'(want_res.long_press_shown),
					8'(got_res.long_press_shown));
			end
		end
	end

	// Result side: random stall bursts, plus a long hold-off on request
	initial begin : receiver
		int unsigned n;
		bit          hold_used;
		hold_used = 1'b0;
		forever begin
			if (rx_hold_cycles != 0 && !hold_used) begin
				n = rx_hold_cycles;
				hold_used = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offer one tick, hold it until transfer; tvalid stays high but for random gaps
	task automatic send_tick(input logic left_up, input logic right_up);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, right_up, left_up};
		do @(posedge clk); while (!s_axis_tready);
		settings_due.push_back(advance_buttons(left_up, right_up));
		ticks_sent++;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (settings_due.size() != 0) @(posedge clk);
	endtask

	task automatic set_press_limit(input cnt_t value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		press_limit = value;
	endtask

	// Hold one button low for low_ticks ticks, then release it (optionally pressing the other one on that release tick)
	task automatic press(input button_t side, input int unsigned low_ticks,
			input bit other_on_release = 1'b0);
		repeat (low_ticks) send_tick(side != BTN_LEFT, side != BTN_RIGHT);
		send_tick(!(other_on_release && side == BTN_RIGHT),
			!(other_on_release && side == BTN_LEFT));
	endtask

	task automatic chord(input button_t lead, input int unsigned lead_ticks,
			input int unsigned latch_ticks, input bit wobble);
		int unsigned pick;
		repeat (lead_ticks) send_tick(lead != BTN_LEFT, lead != BTN_RIGHT);
		send_tick(1'b0, 1'b0);
		repeat (latch_ticks) begin
			pick = wobble ? $urandom_range(0, 2) : 0;
			send_tick(pick == 1, pick == 2);
		end
		send_tick(1'b1, 1'b1);
	endtask

	task automatic check_short_presses();
		press(BTN_RIGHT, 1);           // prescaler already at its ceiling
		press(BTN_LEFT, 1);
		chord(BTN_LEFT, 0, 0, 1'b0);   // hold on
		press(BTN_RIGHT, 1);
		press(BTN_LEFT, 1);
		chord(BTN_RIGHT, 0, 0, 1'b0);  // hold off
	endtask

	task automatic check_long_presses();
		set_press_limit(8'd1);
		press(BTN_RIGHT, 2);           // into pulse mode
		press(BTN_RIGHT, 1);           // burst request
		press(BTN_LEFT, 1);            // view toggle
		press(BTN_LEFT, 2);
		press(BTN_LEFT, 2);            // wrap down to the top mode
		press(BTN_RIGHT, 2);           // wrap up to the bottom mode
	endtask

	task automatic check_random_presses(input cnt_t limit, input int unsigned budget);
		int unsigned stop_at;
		int unsigned short_max;
		int unsigned len;
		button_t     side;
		set_press_limit(limit);
		short_max = (limit == 0) ? 1 : ((limit > 8) ? 8 : int'(limit));
		stop_at = ticks_sent + budget;
		while (ticks_sent < stop_at) begin
			side = button_t'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0: chord(side, $urandom_range(0, 3), $urandom_range(0, 3),
					1'($urandom_range(0, 1)));
				1: send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				default: begin
					if ($urandom_range(0, 3) == 0)
						len = int'(limit) + 1 + $urandom_range(0, 2);
					else
						len = $urandom_range(1, short_max);
					press(side, len, $urandom_range(0, 4) == 0);
				end
			endcase
		end
	endtask

	task automatic check_backpressure();
		set_press_limit(8'd4);
		rx_hold_cycles = 200;
		check_random_presses(8'd4, 80);
		drain_results();
	endtask

	task automatic check_quiet_tail();
		set_press_limit(8'd2);
		quiet = 1'b1;
		check_random_presses(8'd2, 100);
	endtask

	initial begin
		clear_settings_copy();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_short_presses();
		check_long_presses();
		check_random_presses(8'd3, 200);
		check_random_presses(8'd0, 80);
		check_backpressure();
		check_random_presses(8'd255, 200);
		check_random_presses(8'd6, 150);
		check_quiet_tail();

		drain_results();
		repeat (6) @(posedge clk);
		if (settings_due.size() != 0) begin
			$display("%0t: %0d results missing, expected more, actual none",
				$time, settings_due.size());
		end
		if (errors == 0 && settings_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
